// ----- rtl/core/gfcd_pkg.sv -----
// Shared types and constants for the gated frequency counter.
// No dependencies; imported by every module of the block.

package gfcd_pkg;

    localparam int DIGITS = 8;
    localparam int BCD_W = 4;
    localparam int TICK_W = 24;
    localparam int CHAR_W = 6;

    localparam logic [TICK_W-1:0] GATE_RESET = 24'd9999360;
    localparam logic [BCD_W-1:0] BCD_NINE = 4'd9;
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 6'd48;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 6'd32;

    typedef logic [BCD_W-1:0] bcd_t;
    typedef bcd_t [DIGITS-1:0] bcd_vec_t;
    typedef logic [CHAR_W-1:0] char_t;
    typedef char_t [DIGITS-1:0] char_vec_t;

    // Edge count as it stands after the current tick, this tick's edge included
    typedef struct packed {
        bcd_vec_t digits;
        logic over;
    } count_snap_t;

    // Gate status from the tick counter
    typedef struct packed {
        logic due;
        logic done;
    } gate_status_t;

endpackage

// ----- rtl/core/gfcd_gate_timer.sv -----
// Gate length register and reference tick counter.
// Depends on gfcd_pkg.

module gfcd_gate_timer
    import gfcd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [TICK_W-1:0] cfg_data,
    input  logic              tick_accept,
    output gate_status_t      status
);

    logic [TICK_W-1:0] gate_len_reg;
    logic [TICK_W-1:0] tick_reg;
    logic [TICK_W-1:0] tick_inc;
    logic [TICK_W-1:0] tick_next;

    always_comb
    begin
        // 24-bit wrap: a gate length of zero lasts the full counter range
        tick_inc = tick_reg + 1'b1;
        status.due = (tick_inc == gate_len_reg);
        status.done = tick_accept & status.due;
        tick_next = tick_reg;
        if (tick_accept)
        begin
            tick_next = status.due ? '0 : tick_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_len_reg <= GATE_RESET;
            tick_reg <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                gate_len_reg <= cfg_data;
            end
            tick_reg <= tick_next;
        end
    end

endmodule

// ----- rtl/core/gfcd_edge_counter.sv -----
// Rising edge detector and saturating decimal (BCD) edge counter.
// Depends on gfcd_pkg.

module gfcd_edge_counter
    import gfcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        tick_accept,
    input  logic        level,
    input  logic        gate_done,
    output count_snap_t snap
);

    logic     prev_reg;
    logic     prev_next;
    bcd_vec_t digits_reg;
    bcd_vec_t digits_next;
    logic     over_reg;
    logic     over_next;
    bcd_vec_t digits_inc;
    logic     all_nines;
    logic     carry;
    logic     rising;

    always_comb
    begin
        rising = tick_accept & level & ~prev_reg;
        all_nines = 1'b1;
        carry = 1'b1;
        digits_inc = digits_reg;
        // Ripple the decimal carry from the units upwards
        for (int i = 0; i < DIGITS; i++)
        begin
            if (digits_reg[i] != BCD_NINE)
            begin
                all_nines = 1'b0;
            end
            if (carry)
            begin
                if (digits_reg[i] == BCD_NINE)
                begin
                    digits_inc[i] = '0;
                end
                else
                begin
                    digits_inc[i] = digits_reg[i] + 1'b1;
                    carry = 1'b0;
                end
            end
        end

        // Saturate at all nines and flag over-range
        snap.digits = (rising && !all_nines) ? digits_inc : digits_reg;
        snap.over = over_reg | (rising & all_nines);

        prev_next = tick_accept ? level : prev_reg;
        if (gate_done)
        begin
            digits_next = '0;
            over_next = 1'b0;
        end
        else
        begin
            digits_next = snap.digits;
            over_next = snap.over;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= 1'b0;
            digits_reg <= '0;
            over_reg <= 1'b0;
        end
        else
        begin
            prev_reg <= prev_next;
            digits_reg <= digits_next;
            over_reg <= over_next;
        end
    end

endmodule

// ----- rtl/core/gfcd_char_out.sv -----
// Leading-zero blanking, ASCII conversion and the result register.
// Depends on gfcd_pkg.

module gfcd_char_out
    import gfcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  count_snap_t snap,
    input  logic        out_stall,
    output logic        out_valid,
    output char_vec_t   chars,
    output logic        over
);

    logic      valid_reg;
    logic      valid_next;
    char_vec_t chars_reg;
    char_vec_t chars_next;
    logic      over_reg;
    logic      leading;

    always_comb
    begin
        leading = 1'b1;
        // Walk from the most significant digit; blank until the first non-zero
        for (int i = DIGITS - 1; i >= 0; i--)
        begin
            if (snap.digits[i] != '0)
            begin
                leading = 1'b0;
            end
            chars_next[i] = leading ? CHAR_SPACE
                                    : (CHAR_ZERO + {{(CHAR_W-BCD_W){1'b0}}, snap.digits[i]});
        end

        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload holds while stalled; a new load only arrives once the slot frees
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            chars_reg <= chars_next;
            over_reg <= snap.over;
        end
    end

    assign out_valid = valid_reg;
    assign chars = chars_reg;
    assign over = over_reg;

endmodule

// ----- rtl/core/gated_frequency_counter_decimal.sv -----
// Top level of the gated frequency counter with eight-digit ASCII output.
// Depends on gfcd_pkg, gfcd_gate_timer, gfcd_edge_counter, gfcd_char_out.
//
// Channel   Handshake              Payload
// config    cfg_valid/cfg_ready    gate_length_ticks (24 bits)
// input     in_valid/in_stall      signal_level (1 bit)
// output    out_valid/out_stall    eight *_char fields (6 bits), over_range
//
// One tick is taken per cycle unless stalled; its effect on the counters is
// immediate; a gate result appears in the output register the next cycle.
// The edge count is kept in BCD, so the result needs only blanking and ASCII
// offsetting on the way into the output register.
// Reset clears the counters and loads the default gate length of 9999360.
// Input stalls only when a result is waiting, the output is stalled and the
// next tick would close a gate.

module gated_frequency_counter_decimal
    import gfcd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [TICK_W-1:0] gate_length_ticks,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              signal_level,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [CHAR_W-1:0] ten_millions_char,
    output logic [CHAR_W-1:0] millions_char,
    output logic [CHAR_W-1:0] hundred_thousands_char,
    output logic [CHAR_W-1:0] ten_thousands_char,
    output logic [CHAR_W-1:0] thousands_char,
    output logic [CHAR_W-1:0] hundreds_char,
    output logic [CHAR_W-1:0] tens_char,
    output logic [CHAR_W-1:0] units_char,
    output logic              over_range
);

    gate_status_t gate;
    count_snap_t  snap;
    char_vec_t    chars;
    logic         tick_accept;

    assign cfg_ready = 1'b1;
    assign in_stall = out_valid & out_stall & gate.due;
    assign tick_accept = in_valid & ~in_stall;

    gfcd_gate_timer u_gate_timer
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_valid & cfg_ready),
        .cfg_data    (gate_length_ticks),
        .tick_accept (tick_accept),
        .status      (gate)
    );

    gfcd_edge_counter u_edge_counter
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick_accept (tick_accept),
        .level       (signal_level),
        .gate_done   (gate.done),
        .snap        (snap)
    );

    gfcd_char_out u_char_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (gate.done),
        .snap      (snap),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .chars     (chars),
        .over      (over_range)
    );

    assign ten_millions_char = chars[7];
    assign millions_char = chars[6];
    assign hundred_thousands_char = chars[5];
    assign ten_thousands_char = chars[4];
    assign thousands_char = chars[3];
    assign hundreds_char = chars[2];
    assign tens_char = chars[1];
    assign units_char = chars[0];

endmodule

// ----- tb/sv/testbench.sv -----
// Testbench for gated_frequency_counter_decimal: random and directed tick streams, with
// gate readings checked against a cycle-free model of the counter held in this file.
// Depends on gfcd_pkg and the RTL of the block; needs nothing else.

module testbench;
    import gfcd_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_TICKS = 900;
    localparam int WIDE_TICKS = 2 * 123;
    localparam longint COUNT_LIMIT = 10 ** DIGITS - 1;
    localparam logic [TICK_W-1:0] GATE_MAX = '1;

    typedef struct packed {
        char_vec_t chars;
        logic      over;
    } reading_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [TICK_W-1:0] gate_length_ticks = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              signal_level = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [CHAR_W-1:0] ten_millions_char;
    logic [CHAR_W-1:0] millions_char;
    logic [CHAR_W-1:0] hundred_thousands_char;
    logic [CHAR_W-1:0] ten_thousands_char;
    logic [CHAR_W-1:0] thousands_char;
    logic [CHAR_W-1:0] hundreds_char;
    logic [CHAR_W-1:0] tens_char;
    logic [CHAR_W-1:0] units_char;
    logic              over_range;

    // Counter model state
    logic [TICK_W-1:0] gate_len = GATE_RESET;
    logic [TICK_W-1:0] gate_ticks = '0;
    logic [26:0]       counted_edges = '0;
    logic              last_level = 1'b0;
    logic              over_seen = 1'b0;

    reading_t pending_readings [$];
    string    char_names [DIGITS] = '{"units_char", "tens_char", "hundreds_char",
                                      "thousands_char", "ten_thousands_char",
                                      "hundred_thousands_char", "millions_char",
                                      "ten_millions_char"};

    int  error_count = 0;
    int  ticks_sent = 0;
    int  readings_checked = 0;
    int  gate_writes = 0;
    int  burst_left = 0;
    bit  back_to_back = 1'b0;
    int  idle_cycles = 0;
    int  stall_run = 0;
    int  stall_mode = 0;
    int  cycle_count = 0;

    gated_frequency_counter_decimal u_dut (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .cfg_valid              (cfg_valid),
        .cfg_ready              (cfg_ready),
        .gate_length_ticks      (gate_length_ticks),
        .in_valid               (in_valid),
        .in_stall               (in_stall),
        .signal_level           (signal_level),
        .out_valid              (out_valid),
        .out_stall              (out_stall),
        .ten_millions_char      (ten_millions_char),
        .millions_char          (millions_char),
        .hundred_thousands_char (hundred_thousands_char),
        .ten_thousands_char     (ten_thousands_char),
        .thousands_char         (thousands_char),
        .hundreds_char          (hundreds_char),
        .tens_char              (tens_char),
        .units_char             (units_char),
        .over_range             (over_range)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    function automatic reading_t to_reading(input logic [26:0] count, input logic over);
        reading_t         r;
        longint unsigned  rest;
        longint unsigned  divisor;
        longint unsigned  d;
        logic             leading;
        rest = 64'(count);
        divisor = 1;
        leading = 1'b1;
        for (int k = 1; k < DIGITS; k++)
            divisor *= 10;
        for (int k = DIGITS - 1; k >= 0; k--)
        begin
            d = rest / divisor;
            if (d > 9)
                d = 9;
            rest -= d * divisor;
            if (d != 0)
                leading = 1'b0;
            r.chars[k] = leading ? CHAR_SPACE : CHAR_ZERO + char_t'(d);
            divisor /= 10;
        end
        r.over = over;
        return r;
    endfunction

    // Apply one accepted tick to the model; queue a reading when the gate closes
    function automatic void advance_counter(input logic level);
        if (level && !last_level)
        begin
            if (counted_edges >= COUNT_LIMIT)
                over_seen = 1'b1;
            else
                counted_edges++;
        end
        last_level = level;
        gate_ticks = gate_ticks + 1'b1;
        if (gate_ticks == gate_len)
        begin
            pending_readings.push_back(to_reading(counted_edges, over_seen));
            gate_ticks = '0;
            counted_edges = '0;
            over_seen = 1'b0;
        end
    endfunction

    task automatic send_tick(input logic level);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (back_to_back || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        signal_level <= level;
        do
            @(posedge clk);
        while (in_stall);
        advance_counter(level);
        ticks_sent++;
    endtask

    // Write only with the counter idle: all readings in and the pipeline settled
    task automatic write_gate_length(input logic [TICK_W-1:0] value);
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        gate_length_ticks <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        gate_len = value;
        gate_writes++;
    endtask

    // Receive readings, check them, and drive the stall pattern
    always @(posedge clk)
    begin
        reading_t got;
        reading_t want;
        bit       stall_next;
        cycle_count++;
        if (rst_n && out_valid && !out_stall)
        begin
            got.chars = {ten_millions_char, millions_char, hundred_thousands_char,
                         ten_thousands_char, thousands_char, hundreds_char,
                         tens_char, units_char};
            got.over = over_range;
            if (pending_readings.size() == 0)
                report_mismatch("reading arrived with none outstanding");
            else
            begin
                want = pending_readings.pop_front();
                for (int k = 0; k < DIGITS; k++)
                    if (got.chars[k] !== want.chars[k])
                        report_mismatch($sformatf("%s got %0d expected %0d",
                                                  char_names[k], got.chars[k], want.chars[k]));
                if (got.over !== want.over)
                    report_mismatch($sformatf("over_range got %0d expected %0d",
                                              got.over, want.over));
                readings_checked++;
            end
        end
        if (cycle_count % 256 == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: stall_next = 1'b0;
            1: stall_next = ($urandom_range(0, 3) == 0);
            2: stall_next = ($urandom_range(0, 3) != 0);
            default: stall_next = (cycle_count % 3 == 0);
        endcase
        // Cap stall runs so the watchdog never trips on a correct block
        if (stall_next && stall_run >= 24)
            stall_next = 1'b0;
        stall_run = stall_next ? stall_run + 1 : 0;
        out_stall <= stall_next;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Default gate length holds for a few ticks, then a short gate closes it
    task automatic test_reset_gate();
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        write_gate_length(TICK_W'(4));
        send_tick(1'b0);
    endtask

    // One-tick gates: a zero count blanks every place, the units too
    task automatic test_minimum_gate();
        write_gate_length(TICK_W'(1));
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b1);
    endtask

    // Previous level survives the gate boundary, so edges straddle it
    task automatic test_level_across_gates();
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
    endtask

    task automatic test_maximum_gate();
        write_gate_length(GATE_MAX);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        write_gate_length(TICK_W'(5));
        send_tick(1'b1);
        send_tick(1'b1);
    endtask

    // Alternating levels through one gate, so the units place reaches its top digit character
    task automatic test_full_digit();
        write_gate_length(TICK_W'(18));
        for (int k = 0; k < 18; k++)
            send_tick(k[0]);
    endtask

    task automatic test_random_gates();
        int          start;
        int          phase_ticks;
        int          level_mode;
        int          hold;
        logic        level;
        logic [31:0] span;
        start = ticks_sent;
        level = 1'b0;
        hold = 0;
        while (ticks_sent - start < RANDOM_TICKS)
        begin
            span = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 400) : $urandom_range(1, 40);
            write_gate_length(TICK_W'(gate_ticks + span));
            phase_ticks = $urandom_range(20, 150);
            level_mode = $urandom_range(0, 2);
            for (int k = 0; k < phase_ticks; k++)
            begin
                case (level_mode)
                    0: level = 1'($urandom_range(0, 1));
                    1: level = ~level;
                    default:
                    begin
                        if (hold == 0)
                        begin
                            level = ~level;
                            hold = $urandom_range(1, 5);
                        end
                        hold--;
                    end
                endcase
                send_tick(level);
            end
        end
    endtask

    // One long gate at full rate for a three-digit reading
    task automatic test_wide_count();
        write_gate_length(TICK_W'(gate_ticks + WIDE_TICKS));
        back_to_back = 1'b1;
        for (int k = 0; k < WIDE_TICKS; k++)
            send_tick(k[0]);
        back_to_back = 1'b0;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_gate();
        test_minimum_gate();
        test_level_across_gates();
        test_maximum_gate();
        test_full_digit();
        test_random_gates();
        test_wide_count();
        in_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        $display("Sent %0d ticks across %0d gate length settings, extremes included",
                 ticks_sent, gate_writes);
        $display("Checked %0d gate readings with %0d mismatches", readings_checked,
                 error_count);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/gfcd_pkg.sv
rtl/core/gfcd_gate_timer.sv
rtl/core/gfcd_edge_counter.sv
rtl/core/gfcd_char_out.sv
rtl/core/gated_frequency_counter_decimal.sv
tb/sv/testbench.sv
